// ===== hw/rtl/hnu_pkg.sv =====
// hnu_pkg: widths, latencies, constants and the small-index table of the
// harmonic number unit. depends on nothing.
package hnu_pkg;

  localparam int unsigned N_BITS        = 32;
  localparam int unsigned FRAC_BITS     = 40;
  localparam int unsigned OUT_BITS      = 8 + FRAC_BITS;
  localparam int unsigned WORK_FRAC     = 56;
  localparam int unsigned RND_SHIFT     = WORK_FRAC - FRAC_BITS;
  localparam int unsigned TABLE_ENTRIES = 257;
  localparam int unsigned IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int unsigned RECIP_BITS    = 48;
  localparam int unsigned LEAD_BITS     = $clog2(N_BITS);

  localparam int unsigned DIV_STEPS  = WORK_FRAC + 1;
  localparam int unsigned SQ_ITERS   = WORK_FRAC;
  localparam int unsigned DIV_LAT    = DIV_STEPS;
  localparam int unsigned CORR_LAT   = 10;
  localparam int unsigned LOG_LAT    = 1 + 2 * SQ_ITERS + 2;
  localparam int unsigned CORR_DLY   = LOG_LAT - DIV_LAT - CORR_LAT;
  localparam int unsigned PIPE_LAT   = LOG_LAT + 2;

  localparam logic [63:0] GAMMA_Q56 = 64'd41592772053807304;
  localparam logic [55:0] LN2_Q56   = 56'd49946518145322874;
  localparam logic [64:0] OUT_MASK  = (65'd1 << OUT_BITS) - 65'd1;

  typedef logic [OUT_BITS-1:0] harm_t;
  typedef logic [N_BITS-1:0]   index_t;

  // partial sums of truncated reciprocals, rounded to the output format
  function automatic logic [TABLE_ENTRIES-1:0][OUT_BITS-1:0] build_table();
    logic [TABLE_ENTRIES-1:0][OUT_BITS-1:0] t;
    logic [63:0] acc;
    logic [64:0] rnd;
    acc = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k > 0) begin
        acc = acc + ((64'd1 << WORK_FRAC) / 64'(k));
      end
      rnd = 65'(acc >> RND_SHIFT) + 65'(acc[RND_SHIFT-1]);
      t[k] = (rnd > OUT_MASK) ? {OUT_BITS{1'b1}} : rnd[OUT_BITS-1:0];
    end
    return t;
  endfunction

  localparam logic [TABLE_ENTRIES-1:0][OUT_BITS-1:0] HARM_TABLE = build_table();

endpackage

// ===== hw/rtl/hnu_in_if.sv =====
// hnu_in_if: input channel of the harmonic number unit (index n).
// depends on hnu_pkg.
interface hnu_in_if;
  import hnu_pkg::*;
  logic   valid;
  logic   ready;
  index_t n_value;
  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

// ===== hw/rtl/hnu_out_if.sv =====
// hnu_out_if: result channel of the harmonic number unit (H_n).
// depends on hnu_pkg.
interface hnu_out_if;
  import hnu_pkg::*;
  logic  valid;
  logic  ready;
  harm_t harmonic_value;
  modport source (output valid, output harmonic_value, input ready);
  modport sink   (input valid, input harmonic_value, output ready);
endinterface

// ===== hw/rtl/hnu_recip.sv =====
// hnu_recip: pipelined restoring division 2^56 / n, one quotient bit a stage.
// depends on hnu_pkg.
module hnu_recip (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [hnu_pkg::N_BITS-1:0]        n_i,
  output logic [hnu_pkg::RECIP_BITS-1:0]    r_o
);
  import hnu_pkg::*;

  logic [N_BITS-1:0]     rem_q [DIV_STEPS];
  logic [N_BITS-1:0]     rem_d [DIV_STEPS];
  logic [RECIP_BITS-1:0] quo_q [DIV_STEPS];
  logic [RECIP_BITS-1:0] quo_d [DIV_STEPS];
  logic [N_BITS-1:0]     div_q [DIV_STEPS];
  logic [N_BITS-1:0]     div_d [DIV_STEPS];
  logic [N_BITS-1:0]     rem_in [DIV_STEPS];
  logic [RECIP_BITS-1:0] quo_in [DIV_STEPS];
  logic [N_BITS-1:0]     div_in [DIV_STEPS];

  always_comb begin
    rem_in[0] = '0;
    quo_in[0] = '0;
    div_in[0] = n_i;
    for (int s = 1; s < DIV_STEPS; s++) begin
      rem_in[s] = rem_q[s-1];
      quo_in[s] = quo_q[s-1];
      div_in[s] = div_q[s-1];
    end
  end

  always_comb begin
    logic [N_BITS:0] trial;
    logic            qb;
    for (int s = 0; s < DIV_STEPS; s++) begin
      // only the leading dividend bit is set
      trial = {rem_in[s], (s == 0) ? 1'b1 : 1'b0};
      if (trial >= {1'b0, div_in[s]}) begin
        trial = trial - {1'b0, div_in[s]};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      rem_d[s] = trial[N_BITS-1:0];
      quo_d[s] = {quo_in[s][RECIP_BITS-2:0], qb};
      div_d[s] = div_in[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      div_q <= div_d;
    end
  end

  assign r_o = quo_q[DIV_STEPS-1];

endmodule

// ===== hw/rtl/hnu_corr.sv =====
// hnu_corr: series correction r/2 - r^2/12 + r^4/120 from the reciprocal r.
// depends on hnu_pkg.
module hnu_corr (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [hnu_pkg::RECIP_BITS-1:0] r_i,
  output logic [hnu_pkg::RECIP_BITS-1:0] corr_o
);
  import hnu_pkg::*;

  localparam int unsigned DivLo   = 12;
  localparam int unsigned DivHi   = 120;
  localparam int unsigned MulLo   = 5462;
  localparam int unsigned MulHi   = 34953;
  localparam int unsigned DStages = 5;

  // exact for v below 3072
  function automatic logic [7:0] div_lo(input logic [11:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'(MulLo);
    return p[23:16];
  endfunction

  // exact for v below 30720
  function automatic logic [7:0] div_hi(input logic [14:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'(MulHi);
    return p[29:22];
  endfunction

  logic [RECIP_BITS-1:0] r1_q, r2c_q, r3_q, r4c_q;
  logic [47:0] q0_q, q1_q, q2_q;
  logic [39:0] sq_q, sq3_q, sq4_q;
  logic [39:0] t0_q, t1_q, t2_q;
  logic [23:0] r4_q;

  logic [39:0]           alo_q [DStages];
  logic [3:0]            rlo_q [DStages];
  logic [39:0]           qlo_q [DStages];
  logic [39:0]           ahi_q [DStages];
  logic [6:0]            rhi_q [DStages];
  logic [39:0]           qhi_q [DStages];
  logic [RECIP_BITS-1:0] rd_q  [DStages];
  logic [39:0]           alo_d [DStages];
  logic [3:0]            rlo_d [DStages];
  logic [39:0]           qlo_d [DStages];
  logic [39:0]           ahi_d [DStages];
  logic [6:0]            rhi_d [DStages];
  logic [39:0]           qhi_d [DStages];
  logic [RECIP_BITS-1:0] rd_d  [DStages];
  logic [39:0]           alo_in [DStages];
  logic [3:0]            rlo_in [DStages];
  logic [39:0]           qlo_in [DStages];
  logic [39:0]           ahi_in [DStages];
  logic [6:0]            rhi_in [DStages];
  logic [39:0]           qhi_in [DStages];
  logic [RECIP_BITS-1:0] rd_in  [DStages];

  logic [96:0] s2;
  logic [80:0] s4;
  logic [RECIP_BITS-1:0] corr_q;

  assign s2 = (97'(q2_q) << 48) + (97'(q1_q) << 25) + 97'(q0_q);
  assign s4 = (81'(t2_q) << 40) + (81'(t1_q) << 21) + 81'(t0_q);

  always_comb begin
    alo_in[0] = sq4_q;
    rlo_in[0] = '0;
    qlo_in[0] = '0;
    ahi_in[0] = {16'b0, r4_q};
    rhi_in[0] = '0;
    qhi_in[0] = '0;
    rd_in[0]  = r4c_q;
    for (int j = 1; j < DStages; j++) begin
      alo_in[j] = alo_q[j-1];
      rlo_in[j] = rlo_q[j-1];
      qlo_in[j] = qlo_q[j-1];
      ahi_in[j] = ahi_q[j-1];
      rhi_in[j] = rhi_q[j-1];
      qhi_in[j] = qhi_q[j-1];
      rd_in[j]  = rd_q[j-1];
    end
  end

  // one byte of each dividend a stage, most significant first
  always_comb begin
    logic [11:0] vlo;
    logic [14:0] vhi;
    logic [7:0]  dlo, dhi;
    logic [11:0] plo;
    logic [14:0] phi;
    for (int j = 0; j < DStages; j++) begin
      vlo = {rlo_in[j], alo_in[j][39:32]};
      vhi = {rhi_in[j], ahi_in[j][39:32]};
      dlo = div_lo(vlo);
      dhi = div_hi(vhi);
      plo = vlo - 12'(12'(dlo) * 12'(DivLo));
      phi = vhi - 15'(15'(dhi) * 15'(DivHi));
      rlo_d[j] = plo[3:0];
      rhi_d[j] = phi[6:0];
      qlo_d[j] = {qlo_in[j][31:0], dlo};
      qhi_d[j] = {qhi_in[j][31:0], dhi};
      alo_d[j] = {alo_in[j][31:0], 8'b0};
      ahi_d[j] = {ahi_in[j][31:0], 8'b0};
      rd_d[j]  = rd_in[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q  <= 48'(r_i[23:0]) * 48'(r_i[23:0]);
      q1_q  <= 48'(r_i[23:0]) * 48'(r_i[47:24]);
      q2_q  <= 48'(r_i[47:24]) * 48'(r_i[47:24]);
      r1_q  <= r_i;
      sq_q  <= s2[95:56];
      r2c_q <= r1_q;
      t0_q  <= 40'(sq_q[19:0]) * 40'(sq_q[19:0]);
      t1_q  <= 40'(sq_q[19:0]) * 40'(sq_q[39:20]);
      t2_q  <= 40'(sq_q[39:20]) * 40'(sq_q[39:20]);
      sq3_q <= sq_q;
      r3_q  <= r2c_q;
      r4_q  <= s4[79:56];
      sq4_q <= sq3_q;
      r4c_q <= r3_q;
      alo_q <= alo_d;
      rlo_q <= rlo_d;
      qlo_q <= qlo_d;
      ahi_q <= ahi_d;
      rhi_q <= rhi_d;
      qhi_q <= qhi_d;
      rd_q  <= rd_d;
      corr_q <= (rd_q[DStages-1] >> 1) + RECIP_BITS'(qhi_q[DStages-1])
              - RECIP_BITS'(qlo_q[DStages-1]);
    end
  end

  assign corr_o = corr_q;

endmodule

// ===== hw/rtl/hnu_log.sv =====
// hnu_log: pipelined natural log of n in Q8.56, leading-one normalize,
// 56 squaring iterations of two stages each, then a product with ln 2.
// depends on hnu_pkg.
module hnu_log (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [hnu_pkg::N_BITS-1:0] n_i,
  output logic [63:0]                ln_o
);
  import hnu_pkg::*;

  logic [63:0]          x0_q;
  logic [LEAD_BITS-1:0] l0_q;
  logic [LEAD_BITS-1:0] lead;

  logic [63:0]          pa_q [SQ_ITERS];
  logic [62:0]          pb_q [SQ_ITERS];
  logic [61:0]          pc_q [SQ_ITERS];
  logic [WORK_FRAC-1:0] fa_q [SQ_ITERS];
  logic [LEAD_BITS-1:0] la_q [SQ_ITERS];
  logic [63:0]          xb_q [SQ_ITERS];
  logic [WORK_FRAC-1:0] fb_q [SQ_ITERS];
  logic [LEAD_BITS-1:0] lb_q [SQ_ITERS];

  logic [63:0]          pa_d [SQ_ITERS];
  logic [62:0]          pb_d [SQ_ITERS];
  logic [61:0]          pc_d [SQ_ITERS];
  logic [63:0]          xb_d [SQ_ITERS];
  logic [WORK_FRAC-1:0] fb_d [SQ_ITERS];

  logic [63:0]          x_in [SQ_ITERS];
  logic [WORK_FRAC-1:0] f_in [SQ_ITERS];
  logic [LEAD_BITS-1:0] l_in [SQ_ITERS];

  logic [60:0]  lg2;
  logic [63:0]  m00_q;
  logic [55:0]  m01_q;
  logic [60:0]  m10_q;
  logic [52:0]  m11_q;
  logic [127:0] msum;
  logic [63:0]  ln_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < N_BITS; i++) begin
      if (n_i[i]) begin
        lead = LEAD_BITS'(i);
      end
    end
  end

  always_comb begin
    x_in[0] = x0_q;
    f_in[0] = '0;
    l_in[0] = l0_q;
    for (int i = 1; i < SQ_ITERS; i++) begin
      x_in[i] = xb_q[i-1];
      f_in[i] = fb_q[i-1];
      l_in[i] = lb_q[i-1];
    end
  end

  always_comb begin
    logic [127:0] prod;
    logic [63:0]  y;
    for (int i = 0; i < SQ_ITERS; i++) begin
      pa_d[i] = 64'(x_in[i][31:0]) * 64'(x_in[i][31:0]);
      pb_d[i] = 63'(x_in[i][31:0]) * 63'(x_in[i][62:32]);
      pc_d[i] = 62'(x_in[i][62:32]) * 62'(x_in[i][62:32]);
      prod = (128'(pc_q[i]) << 64) + (128'(pb_q[i]) << 33) + 128'(pa_q[i]);
      y = prod[125:62];
      if (y[63]) begin
        xb_d[i] = {1'b0, y[63:1]};
        fb_d[i] = {fa_q[i][WORK_FRAC-2:0], 1'b1};
      end else begin
        xb_d[i] = y;
        fb_d[i] = {fa_q[i][WORK_FRAC-2:0], 1'b0};
      end
    end
  end

  assign lg2  = {lb_q[SQ_ITERS-1], fb_q[SQ_ITERS-1]};
  assign msum = (128'(m11_q) << 64) + (128'(m01_q) << 32) + (128'(m10_q) << 32)
              + 128'(m00_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= {32'b0, n_i} << (7'd62 - 7'(lead));
      l0_q  <= lead;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      pc_q  <= pc_d;
      fa_q  <= f_in;
      la_q  <= l_in;
      xb_q  <= xb_d;
      fb_q  <= fb_d;
      lb_q  <= la_q;
      m00_q <= 64'(lg2[31:0]) * 64'(LN2_Q56[31:0]);
      m01_q <= 56'(lg2[31:0]) * 56'(LN2_Q56[55:32]);
      m10_q <= 61'(lg2[60:32]) * 61'(LN2_Q56[31:0]);
      m11_q <= 53'(lg2[60:32]) * 53'(LN2_Q56[55:32]);
      ln_q  <= msum[119:56];
    end
  end

  assign ln_o = ln_q;

endmodule

// ===== hw/rtl/harmonic_number_unit_top.sv =====
// harmonic_number_unit_top: harmonic number H_n, table below 257, series above.
// depends on hnu_pkg, hnu_in_if, hnu_out_if, hnu_recip, hnu_corr, hnu_log.
//
// usage:
//   in_i carries one index n_value per item, out_o one harmonic_value per
//   item (Q8.40, unsigned), both valid/ready, in order.
//   the pipeline is 117 register stages deep, set by the 56 two-stage
//   squaring iterations of the log pipeline plus normalize, ln 2
//   product, final sum and rounding stages. throughput is one item per
//   cycle while out_o does not stall; the reciprocal divider (57 stages)
//   and the correction terms run beside the log and are delay-matched.
//   in_i.ready is high whenever the output register is empty or is being
//   taken; a stall on out_o freezes the whole pipeline, nothing is lost.
//   reset clears all stage valid bits; payload registers are not reset.
module harmonic_number_unit_top (
  input logic      clk_i,
  input logic      rst_ni,
  hnu_in_if.sink   in_i,
  hnu_out_if.source out_o
);
  import hnu_pkg::*;

  logic                  en;
  logic [PIPE_LAT-1:0]   v_q;
  logic [RECIP_BITS-1:0] recip;
  logic [RECIP_BITS-1:0] corr;
  logic [63:0]           ln;
  logic [RECIP_BITS-1:0] cd_q [CORR_DLY];
  logic [IDX_BITS:0]     ix_q [LOG_LAT];
  logic                  in_table;
  logic [IDX_BITS-1:0]   idx;
  logic [63:0]           sum_q;
  harm_t                 tab_q;
  logic                  sm_q;
  logic [OUT_BITS:0]     rnd;
  harm_t                 out_q;

  assign en       = !v_q[PIPE_LAT-1] || out_o.ready;
  assign in_table = (in_i.n_value < N_BITS'(TABLE_ENTRIES));
  assign idx      = in_table ? in_i.n_value[IDX_BITS-1:0] : '0;

  hnu_recip u_recip (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (in_i.n_value),
    .r_o   (recip)
  );

  hnu_corr u_corr (
    .clk_i  (clk_i),
    .en_i   (en),
    .r_i    (recip),
    .corr_o (corr)
  );

  hnu_log u_log (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (in_i.n_value),
    .ln_o  (ln)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], in_i.valid};
    end
  end

  assign rnd = {1'b0, sum_q[63:RND_SHIFT]} + (OUT_BITS+1)'(sum_q[RND_SHIFT-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= corr;
      for (int i = 1; i < CORR_DLY; i++) begin
        cd_q[i] <= cd_q[i-1];
      end
      ix_q[0] <= {in_table, idx};
      for (int i = 1; i < LOG_LAT; i++) begin
        ix_q[i] <= ix_q[i-1];
      end
      sum_q <= GAMMA_Q56 + ln + 64'(cd_q[CORR_DLY-1]);
      tab_q <= HARM_TABLE[ix_q[LOG_LAT-1][IDX_BITS-1:0]];
      sm_q  <= ix_q[LOG_LAT-1][IDX_BITS];
      if (sm_q) begin
        out_q <= tab_q;
      end else if (rnd[OUT_BITS]) begin
        out_q <= '1;
      end else begin
        out_q <= rnd[OUT_BITS-1:0];
      end
    end
  end

  assign in_i.ready           = en;
  assign out_o.valid          = v_q[PIPE_LAT-1];
  assign out_o.harmonic_value = out_q;

endmodule

// ===== hw/rtl/hnu_checker.sv =====
// hnu_checker: port-level assertions for harmonic_number_unit_top, and the
// bind that attaches it. depends on hnu_pkg.
module hnu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [hnu_pkg::OUT_BITS-1:0] out_value_i
);
  import hnu_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // empty output register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // a stalled result freezes the pipeline
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("item taken while pipeline stalled");

  // H_n stays below 32 for any 32-bit index
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_value_i[OUT_BITS-1:OUT_BITS-3] == 3'b000))
    else $error("result out of range");

endmodule

bind harmonic_number_unit_top hnu_checker u_hnu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.harmonic_value)
);

// ===== tb/harmonic_number_unit_top_test.sv =====
// harmonic_number_unit_top_test: drives random and edge-case indices into
// the harmonic number unit and checks every H_n against a bit-exact predictor.
// depends on hnu_pkg, hnu_in_if, hnu_out_if and harmonic_number_unit_top.
module harmonic_number_unit_top_test;
  import hnu_pkg::*;

  localparam logic [63:0] GAMMA_FIX = 64'd41592772053807304;
  localparam logic [63:0] LN2_FIX   = 64'd49946518145322874;
  localparam int          N_RANDOM  = 1330;

  class harmonic_scoreboard;
    harm_t       expected_q[$];
    logic [63:0] partial_sums[TABLE_ENTRIES];
    int          errors;
    int          checked;
    int          table_hits;
    int          series_hits;

    function new();
      logic [63:0] acc;
      acc = '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (k > 0) acc = acc + ((64'd1 << 56) / 64'(k));
        partial_sums[k] = acc;
      end
      errors = 0;
      checked = 0;
      table_hits = 0;
      series_hits = 0;
    endfunction

    function logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> s);
    endfunction

    function logic [63:0] natural_log(logic [63:0] n);
      int          lead;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] log2v;
      lead = 0;
      frac = '0;
      for (int i = 0; i < 64; i++) if (n[i]) lead = i;
      x = n << (62 - lead);
      for (int i = 0; i < 56; i++) begin
        x = mul_shr(x, x, 62);
        frac = frac << 1;
        if (x[63]) begin
          x = x >> 1;
          frac[0] = 1'b1;
        end
      end
      log2v = (64'(lead) << 56) + frac;
      return mul_shr(log2v, LN2_FIX, 56);
    endfunction

    function harm_t harmonic_of(index_t idx);
      logic [63:0] n;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] r4;
      logic [63:0] rounded;
      n = 64'(idx);
      if (n < TABLE_ENTRIES) begin
        v = partial_sums[n];
        table_hits++;
      end else begin
        r  = (64'd1 << 56) / n;
        r2 = mul_shr(r, r, 56);
        r4 = mul_shr(r2, r2, 56);
        v  = GAMMA_FIX + natural_log(n);
        v  = v + r / 2;
        v  = v + r4 / 120;
        v  = v - r2 / 12;
        series_hits++;
      end
      rounded = (v >> 16) + 64'(v[15]);
      if (rounded > 64'hFFFF_FFFF_FFFF) rounded = 64'hFFFF_FFFF_FFFF;
      return rounded[47:0];
    endfunction

    function void note_index(index_t idx);
      expected_q.push_back(harmonic_of(idx));
    endfunction

    function void check_result(harm_t got);
      harm_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: harmonic_value mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;
  harmonic_scoreboard sb;

  hnu_in_if  in_if();
  hnu_out_if out_if();

  harmonic_number_unit_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_index(in_if.n_value);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.harmonic_value);
  end

  always @(negedge clk_i) begin
    out_if.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  task automatic send_index(index_t idx);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.n_value = idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  function automatic index_t random_index();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return index_t'($urandom_range(0, TABLE_ENTRIES - 1));
    if (pick < 45) return index_t'($urandom_range(TABLE_ENTRIES, 2000));
    return index_t'($urandom >> $urandom_range(0, 31));
  endfunction

  initial begin
    index_t directed[$];
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.n_value = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // table edges, series start, powers of two, full-width index
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd255, 32'd256, 32'd257, 32'd258,
                 32'd511, 32'd512, 32'd1000, 32'd65536, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'd1_000_000};
    foreach (directed[i]) send_index(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 300 && i < 600);
      if (i == 700) begin
        while (sb.expected_q.size() != 0) @(negedge clk_i);
      end
      send_index(random_index());
    end
    calm = 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);

    $display("checked %0d results: %0d table indices, %0d series indices",
             sb.checked, sb.table_hits, sb.series_hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
